FILE: rtl/core/sdl_pkg.sv
// ----------------------------------------------------------------------------
// sdl_pkg
// Types and constants shared by the step/direction DAC level emulator.
// ----------------------------------------------------------------------------
package sdl_pkg;

    typedef enum logic [2:0] {
        OP_WRITE_PIN  = 3'd0,
        OP_TOGGLE_PIN = 3'd1,
        OP_STEP_COUNT = 3'd2,
        OP_SET_LEVEL  = 3'd3,
        OP_REINIT     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        PIN_DIR  = 2'd0,
        PIN_STEP = 2'd1,
        PIN_STOP = 2'd2,
        PIN_NONE = 2'd3
    } pin_t;

    localparam logic [7:0]  FRAME_CMD = 8'h18;
    localparam logic [2:0]  INIT_LAST = 3'd5;
    localparam logic [15:0] MAX_LEVEL_RESET = 16'hFFFF;

    localparam logic [7:0] CMD_INT_REF  = 8'h38;
    localparam logic [7:0] CMD_GAIN     = 8'h02;
    localparam logic [7:0] CMD_LDAC     = 8'h30;
    localparam logic [7:0] CMD_PWR      = 8'h20;
    localparam logic [7:0] CMD_RESET    = 8'h28;
    localparam logic [7:0] CMD_CLR_ALL  = 8'h1F;
    localparam logic [15:0] BOTH_CH     = 16'h0003;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        channel;
        logic [1:0]  pin_select;
        logic        pin_value;
        logic [31:0] step_count;
        logic [15:0] new_level;
    } item_t;

    typedef struct packed {
        logic [15:0] level;
        logic        dir;
        logic        step;
        logic        stop;
    } chan_t;

    typedef struct packed {
        logic        frame_valid;
        logic [23:0] spi_frame;
        logic [15:0] level_now;
        logic        pin_state;
        logic        at_stop;
        logic        last;
    } result_t;

    function automatic logic [23:0] init_frame(input logic [2:0] idx);
        logic [23:0] f;
        case (idx)
            3'd0:    f = {CMD_RESET, 16'h0001};
            3'd1:    f = {CMD_INT_REF, 16'h0001};
            3'd2:    f = {CMD_GAIN, BOTH_CH};
            3'd3:    f = {CMD_LDAC, BOTH_CH};
            3'd4:    f = {CMD_CLR_ALL, 16'h0000};
            3'd5:    f = {CMD_PWR, BOTH_CH};
            default: f = 24'h000000;
        endcase
        return f;
    endfunction

    function automatic logic pin_of(input chan_t c, input logic [1:0] sel);
        logic p;
        case (pin_t'(sel))
            PIN_DIR:  p = c.dir;
            PIN_STEP: p = c.step;
            PIN_STOP: p = c.stop;
            default:  p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/sdl_exec.sv
// ----------------------------------------------------------------------------
// sdl_exec
// Decodes one request against the addressed channel's state and forms the
// next state and one result.
// ----------------------------------------------------------------------------
module sdl_exec (
    input  sdl_pkg::item_t   item,
    input  logic             ch_ok,
    input  sdl_pkg::chan_t   cur,
    input  logic [15:0]      max_level,
    input  logic [2:0]       init_idx,
    output sdl_pkg::chan_t   nxt,
    output sdl_pkg::result_t res
);
    import sdl_pkg::*;

    logic [31:0] mv_count;
    logic [32:0] up_sum;
    logic [31:0] dn_thr;
    logic [15:0] mv_level;
    logic        mv_stop;
    logic        old_pin;
    logic        new_pin;
    logic        fv;
    logic [23:0] frame;
    logic        is_last;

    always_comb begin
        mv_count = (op_t'(item.opcode) == OP_STEP_COUNT) ? item.step_count : 32'd1;
        dn_thr   = mv_count;
        up_sum   = {17'd0, cur.level} + {1'b0, mv_count};
        if (cur.dir) begin
            mv_level = (up_sum <= {17'd0, max_level}) ? up_sum[15:0] : max_level;
            mv_stop  = 1'b0;
        end else if ({16'd0, cur.level} > dn_thr) begin
            mv_level = cur.level - mv_count[15:0];
            mv_stop  = 1'b0;
        end else begin
            mv_level = 16'd0;
            mv_stop  = 1'b1;
        end
    end

    always_comb begin
        nxt     = cur;
        fv      = 1'b0;
        frame   = 24'd0;
        is_last = 1'b1;
        old_pin = pin_of(cur, item.pin_select);
        new_pin = (op_t'(item.opcode) == OP_TOGGLE_PIN) ? ~old_pin : item.pin_value;
        case (op_t'(item.opcode))
            OP_WRITE_PIN, OP_TOGGLE_PIN: begin
                if (pin_t'(item.pin_select) != PIN_NONE && new_pin != old_pin) begin
                    case (pin_t'(item.pin_select))
                        PIN_DIR:  nxt.dir  = new_pin;
                        PIN_STEP: nxt.step = new_pin;
                        PIN_STOP: nxt.stop = new_pin;
                        default:  nxt.dir  = cur.dir;
                    endcase
                    if (pin_t'(item.pin_select) == PIN_STEP && !old_pin) begin
                        nxt.level = mv_level;
                        nxt.stop  = mv_stop;
                        fv        = 1'b1;
                    end
                end
            end
            OP_STEP_COUNT: begin
                if (pin_t'(item.pin_select) == PIN_STEP) begin
                    nxt.level = mv_level;
                    nxt.stop  = mv_stop;
                    fv        = 1'b1;
                end
            end
            OP_SET_LEVEL: begin
                nxt.level = item.new_level;
                fv        = 1'b1;
            end
            OP_REINIT: begin
                fv      = 1'b1;
                is_last = (init_idx == INIT_LAST);
            end
            default: fv = 1'b0;
        endcase
        if (fv) begin
            frame = (op_t'(item.opcode) == OP_REINIT) ? init_frame(init_idx)
                  : {FRAME_CMD | {7'd0, item.channel}, nxt.level};
        end
    end

    always_comb begin
        if (ch_ok) begin
            res.frame_valid = fv;
            res.spi_frame   = frame;
            res.level_now   = nxt.level;
            res.pin_state   = pin_of(nxt, item.pin_select);
            res.at_stop     = nxt.stop;
            res.last        = is_last;
        end else begin
            res             = '0;
            res.last        = 1'b1;
        end
    end

endmodule

FILE: rtl/core/step_dir_to_dac_level_emulator.sv
// ----------------------------------------------------------------------------
// step_dir_to_dac_level_emulator
// Drives converter channels as virtual steppers and emits 24-bit SPI frames.
//
//   channel   dir  handshake         payload
//   s_        in   tvalid/tready     tuser opcode, tdata pin request fields
//   m_        out  tvalid/tready     tuser frame_valid, tdata result, tlast
//   cfg_      in   we                wdata max_level
//
// One request per cycle while the result side is not stalled; a reinit holds
// its request for six frames, stepped by the init frame counter.
// Reset: levels 0, flags clear, stop set, max_level 65535; no clearing pass.
// The input register takes a new request while the result register is
// drained; a stalled result holds both registers.
// ----------------------------------------------------------------------------
module step_dir_to_dac_level_emulator #(
    parameter int CHANNELS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel, pin_select, pin_value, step_count, new_level, zero pad
    input  logic [55:0] s_tdata,
    // opcode
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // spi_frame, level_now, pin_state, at_stop, zero pad
    output logic [47:0] m_tdata,
    // frame_valid
    output logic        m_tuser,
    output logic        m_tlast
);
    import sdl_pkg::*;

    logic           in_valid_reg;
    item_t          item_reg;
    logic [2:0]     init_idx_reg;
    logic [15:0]    max_level_reg;
    logic [15:0]    level_reg [CHANNELS];
    logic           dir_reg   [CHANNELS];
    logic           step_reg  [CHANNELS];
    logic           stop_reg  [CHANNELS];
    logic           m_valid_reg;
    result_t        res_reg;

    logic           ch_ok;
    chan_t          cur;
    chan_t          nxt;
    result_t        res;
    logic           fire;
    logic           consume;

    always_comb begin
        ch_ok = (int'(item_reg.channel) < CHANNELS);
        cur   = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (item_reg.channel == 1'(i)) begin
                cur.level = level_reg[i];
                cur.dir   = dir_reg[i];
                cur.step  = step_reg[i];
                cur.stop  = stop_reg[i];
            end
        end
    end

    sdl_exec u_exec (
        .item      (item_reg),
        .ch_ok     (ch_ok),
        .cur       (cur),
        .max_level (max_level_reg),
        .init_idx  (init_idx_reg),
        .nxt       (nxt),
        .res       (res)
    );

    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign consume  = fire && res.last;
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            init_idx_reg  <= 3'd0;
            max_level_reg <= MAX_LEVEL_RESET;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                level_reg[i] <= 16'd0;
                dir_reg[i]   <= 1'b0;
                step_reg[i]  <= 1'b0;
                stop_reg[i]  <= 1'b1;
            end
        end else begin
            if (cfg_we) begin
                max_level_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                init_idx_reg <= 3'd0;
            end else if (fire) begin
                init_idx_reg <= init_idx_reg + 3'd1;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (fire && ch_ok) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (item_reg.channel == 1'(i)) begin
                        level_reg[i] <= nxt.level;
                        dir_reg[i]   <= nxt.dir;
                        step_reg[i]  <= nxt.step;
                        stop_reg[i]  <= nxt.stop;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode     <= s_tuser;
            item_reg.channel    <= s_tdata[0];
            item_reg.pin_select <= s_tdata[2:1];
            item_reg.pin_value  <= s_tdata[3];
            item_reg.step_count <= s_tdata[35:4];
            item_reg.new_level  <= s_tdata[51:36];
        end
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.frame_valid;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {6'd0, res_reg.at_stop, res_reg.pin_state,
                       res_reg.level_now, res_reg.spi_frame};

endmodule

FILE: verif/tb_step_dir_to_dac_level_emulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_step_dir_to_dac_level_emulator
// Self-checking bench for the step/direction DAC level emulator. It sends pin
// requests with bursty gaps against a stalling result side, predicts every
// SPI frame, level and flag in a scoreboard, and repeats the run under
// several max_level settings.
// ----------------------------------------------------------------------------
module tb_step_dir_to_dac_level_emulator;
    import sdl_pkg::*;

    localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
    localparam logic [7:0]  LEVEL_CMD    = 8'h18;
    localparam logic [23:0] INIT_SEQ [6] = '{24'h280001, 24'h380001, 24'h020003,
                                             24'h300003, 24'h1F0000, 24'h200003};

    class dac_level_scoreboard;
        logic [15:0] max_level;
        logic [15:0] level [2];
        bit          pins [2][4];
        result_t     expected_q [$];
        int          errors;

        function new();
            max_level = MAX_LEVEL_RESET;
            errors    = 0;
            for (int c = 0; c < 2; c++) begin
                level[c] = '0;
                for (int p = 0; p < 4; p++) pins[c][p] = 1'b0;
                pins[c][PIN_STOP] = 1'b1;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(int ch, int sel, bit valid, logic [23:0] frame, bit last);
            result_t r;
            r.frame_valid = valid;
            r.spi_frame   = valid ? frame : 24'h0;
            r.level_now   = level[ch];
            r.pin_state   = pins[ch][sel];
            r.at_stop     = pins[ch][PIN_STOP];
            r.last        = last;
            expected_q.push_back(r);
        endfunction

        function void advance(int ch, logic [31:0] count, bit single);
            logic [32:0] sum;
            logic [31:0] floor_cnt;
            if (pins[ch][PIN_DIR]) begin
                sum = {17'd0, level[ch]} + {1'b0, count};
                level[ch] = (sum > {17'd0, max_level}) ? max_level : sum[15:0];
                pins[ch][PIN_STOP] = 1'b0;
            end else begin
                floor_cnt = single ? 32'd1 : count;
                if ({16'd0, level[ch]} > floor_cnt) begin
                    level[ch] = level[ch] - count[15:0];
                    pins[ch][PIN_STOP] = 1'b0;
                end else begin
                    level[ch] = '0;
                    pins[ch][PIN_STOP] = 1'b1;
                end
            end
        endfunction

        function void note_request(item_t it);
            int ch;
            int sel;
            bit old_pin;
            bit new_pin;
            bit sends;
            ch    = int'(it.channel);
            sel   = int'(it.pin_select);
            sends = 1'b0;
            case (it.opcode)
                OP_WRITE_PIN, OP_TOGGLE_PIN: begin
                    if (sel != PIN_NONE) begin
                        old_pin = pins[ch][sel];
                        new_pin = (it.opcode == OP_TOGGLE_PIN) ? !old_pin : it.pin_value;
                        if (new_pin != old_pin) begin
                            pins[ch][sel] = new_pin;
                            if (sel == PIN_STEP && !old_pin) begin
                                advance(ch, 32'd1, 1'b1);
                                sends = 1'b1;
                            end
                        end
                    end
                end
                OP_STEP_COUNT: begin
                    if (sel == PIN_STEP) begin
                        advance(ch, it.step_count, 1'b0);
                        sends = 1'b1;
                    end
                end
                OP_SET_LEVEL: begin
                    level[ch] = it.new_level;
                    sends = 1'b1;
                end
                default: ;
            endcase
            if (it.opcode == OP_REINIT) begin
                for (int k = 0; k < 6; k++) push_result(ch, sel, 1'b1, INIT_SEQ[k], k == 5);
            end else if (sends) begin
                push_result(ch, sel, 1'b1, {LEVEL_CMD | {7'd0, it.channel}, level[ch]}, 1'b1);
            end else begin
                push_result(ch, sel, 1'b0, 24'h0, 1'b1);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("ERROR %0t: %s", $time, msg);
        endtask

        task check_frame(result_t got);
            result_t exp;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp = expected_q.pop_front();
            if (got.frame_valid !== exp.frame_valid)
                report($sformatf("frame_valid %b, want %b", got.frame_valid, exp.frame_valid));
            if (got.spi_frame !== exp.spi_frame)
                report($sformatf("spi_frame %h, want %h", got.spi_frame, exp.spi_frame));
            if (got.level_now !== exp.level_now)
                report($sformatf("level_now %h, want %h", got.level_now, exp.level_now));
            if (got.pin_state !== exp.pin_state)
                report($sformatf("pin_state %b, want %b", got.pin_state, exp.pin_state));
            if (got.at_stop !== exp.at_stop)
                report($sformatf("at_stop %b, want %b", got.at_stop, exp.at_stop));
            if (got.last !== exp.last)
                report($sformatf("last %b, want %b", got.last, exp.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    dac_level_scoreboard board;
    int unsigned         burst_left;

    always #5 aclk = ~aclk;

    step_dir_to_dac_level_emulator #(
        .CHANNELS(2)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic item_t make_request(logic [2:0] op, logic ch, logic [1:0] sel,
                                           logic val, logic [31:0] count,
                                           logic [15:0] lvl);
        item_t it;
        it.opcode     = op;
        it.channel    = ch;
        it.pin_select = sel;
        it.pin_value  = val;
        it.step_count = count;
        it.new_level  = lvl;
        return it;
    endfunction

    function automatic item_t random_request();
        item_t       it;
        int unsigned pick;
        it.channel    = 1'($urandom_range(0, 1));
        it.pin_value  = 1'($urandom_range(0, 1));
        it.pin_select = ($urandom_range(0, 19) == 0) ? PIN_NONE : 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 30)      it.opcode = OP_TOGGLE_PIN;
        else if (pick < 50) it.opcode = OP_WRITE_PIN;
        else if (pick < 70) it.opcode = OP_STEP_COUNT;
        else if (pick < 82) it.opcode = OP_SET_LEVEL;
        else if (pick < 90) it.opcode = OP_REINIT;
        else                it.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (it.opcode != OP_SET_LEVEL && it.pin_select != PIN_NONE && $urandom_range(0, 1))
            it.pin_select = PIN_STEP;
        case ($urandom_range(0, 3))
            0:       it.step_count = $urandom_range(0, 3);
            1:       it.step_count = $urandom_range(0, 300);
            2:       it.step_count = $urandom;
            default: it.step_count = $urandom_range(65533, 65537);
        endcase
        case ($urandom_range(0, 2))
            0:       it.new_level = 16'($urandom_range(0, 3));
            1:       it.new_level = 16'($urandom_range(65532, 65535));
            default: it.new_level = 16'($urandom);
        endcase
        return it;
    endfunction

    task send_request(item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, it.new_level, it.step_count, it.pin_value, it.pin_select,
                     it.channel};
        s_tuser  <= it.opcode;
        do @(posedge aclk); while (!s_tready);
        board.note_request(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task write_max_level(logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.max_level = value;
    endtask

    task random_phase(int count, bit hold_midway);
        for (int i = 0; i < count; i++) begin
            if (hold_midway && i == count / 2) drain_results();
            send_request(random_request());
        end
    endtask

    // receiver stall pattern: re-roll a 32-bit mask of ready bits
    initial begin
        bit [31:0]   mask;
        int unsigned mode;
        m_tready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            case (mode)
                0:       mask = '1;
                1:       mask = $urandom;
                2:       mask = $urandom & $urandom & $urandom;
                default: mask = $urandom | $urandom;
            endcase
            for (int k = 0; k < 32; k++) begin
                @(posedge aclk);
                m_tready <= mask[k];
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_frame(result_t'({m_tuser, m_tdata[23:0], m_tdata[39:24],
                                         m_tdata[40], m_tdata[41], m_tlast}));
    end

    initial begin
        #2_000_000;
        $display("FAIL step_dir_to_dac_level_emulator");
        $finish;
    end

    initial begin
        board      = new();
        burst_left = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(make_request(OP_WRITE_PIN,  1'b0, PIN_DIR,  1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_TOGGLE_PIN, 1'b0, PIN_STEP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_TOGGLE_PIN, 1'b0, PIN_STEP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_WRITE_PIN,  1'b0, PIN_DIR,  1'b1, 32'd0, 16'd0));
        send_request(make_request(OP_WRITE_PIN,  1'b0, PIN_STEP, 1'b1, 32'd0, 16'd0));
        send_request(make_request(OP_WRITE_PIN,  1'b0, PIN_STEP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_STEP_COUNT, 1'b0, PIN_STEP, 1'b0, 32'hFFFF_FFFF, 16'd0));
        send_request(make_request(OP_TOGGLE_PIN, 1'b0, PIN_STEP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_STEP_COUNT, 1'b0, PIN_DIR,  1'b1, 32'd5, 16'd0));
        send_request(make_request(OP_TOGGLE_PIN, 1'b0, PIN_DIR,  1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_STEP_COUNT, 1'b0, PIN_STEP, 1'b0, 32'd65534, 16'd0));
        send_request(make_request(OP_TOGGLE_PIN, 1'b0, PIN_STEP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_TOGGLE_PIN, 1'b0, PIN_STEP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_SET_LEVEL,  1'b1, PIN_NONE, 1'b0, 32'd0, 16'd2));
        send_request(make_request(OP_WRITE_PIN,  1'b1, PIN_STEP, 1'b1, 32'd0, 16'd0));
        send_request(make_request(OP_STEP_COUNT, 1'b1, PIN_STEP, 1'b1, 32'd1, 16'd0));
        send_request(make_request(OP_STEP_COUNT, 1'b1, PIN_STEP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_SET_LEVEL,  1'b1, PIN_STOP, 1'b1, 32'd0, 16'hFFFF));
        send_request(make_request(OP_STEP_COUNT, 1'b1, PIN_STEP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_WRITE_PIN,  1'b1, PIN_STOP, 1'b1, 32'd0, 16'd0));
        send_request(make_request(OP_TOGGLE_PIN, 1'b1, PIN_STOP, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_WRITE_PIN,  1'b1, PIN_NONE, 1'b1, 32'd0, 16'd0));
        send_request(make_request(OP_TOGGLE_PIN, 1'b1, PIN_NONE, 1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_REINIT,     1'b0, PIN_STEP, 1'b1, 32'd0, 16'd0));
        send_request(make_request(OP_UNUSED_LO,  1'b1, PIN_DIR,  1'b0, 32'd0, 16'd0));
        send_request(make_request(OP_UNUSED_HI,  1'b0, PIN_STOP, 1'b1, 32'd0, 16'd0));

        drain_results();
        write_max_level(16'd0);
        random_phase(25, 1'b0);
        drain_results();
        write_max_level(16'd1);
        random_phase(25, 1'b0);
        drain_results();
        write_max_level(16'($urandom_range(2, 300)));
        random_phase(40, 1'b1);
        drain_results();
        write_max_level(16'hFFFF);
        random_phase(45, 1'b0);
        drain_results();
        repeat (10) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0)
            $display("PASS step_dir_to_dac_level_emulator");
        else
            $display("FAIL step_dir_to_dac_level_emulator");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sdl_pkg.sv
rtl/core/sdl_exec.sv
rtl/core/step_dir_to_dac_level_emulator.sv
verif/tb_step_dir_to_dac_level_emulator.sv
